// ===== hdl/mbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_pkg
// shared types, register indexes and pattern byte lookup for the scanner
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int unsigned PAT_BYTES = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LO  = 3'd0,
    REG_PATTERN_HI  = 3'd1,
    REG_CARE_MASK   = 3'd2,
    REG_PATTERN_LEN = 3'd3,
    REG_TARGET      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pattern;
    logic [PAT_BYTES-1:0]   care;
    logic [4:0]             length;
    logic [31:0]            target;
  } cfg_t;

  function automatic logic [7:0] pat_byte(input logic [8*PAT_BYTES-1:0] pattern,
                                          input logic [3:0] idx);
    pat_byte = pattern[8*idx +: 8];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mbps_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// configuration register bank written through the cfg beat channel
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data,
  output mbps_pkg::cfg_t                       cfg
);

  logic [63:0] pat_lo_r;
  logic [63:0] pat_hi_r;
  logic [15:0] care_r;
  logic [4:0]  len_r;
  logic [31:0] target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= 16'hFFFF;
      len_r    <= 5'd1;
      target_r <= 32'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mbps_pkg::REG_PATTERN_LO:  pat_lo_r <= cfg_data;
        mbps_pkg::REG_PATTERN_HI:  pat_hi_r <= cfg_data;
        mbps_pkg::REG_CARE_MASK:   care_r   <= cfg_data[15:0];
        mbps_pkg::REG_PATTERN_LEN: len_r    <= cfg_data[4:0];
        mbps_pkg::REG_TARGET:      target_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern = {pat_hi_r, pat_lo_r};
  assign cfg.care    = care_r;
  assign cfg.length  = len_r;
  assign cfg.target  = target_r;

endmodule
`default_nettype wire

// ===== hdl/mbps_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_cell
// one window byte: shifts toward its neighbor and checks its pattern byte
// ----------------------------------------------------------------------------
module mbps_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned LEN_W    = 5
) (
  input  wire logic                                clk,
  input  wire logic                                shift_en,
  input  wire logic [7:0]                          byte_in,
  input  wire logic [LEN_W-1:0]                    len,
  input  wire logic [8*mbps_pkg::PAT_BYTES-1:0]    pattern,
  input  wire logic [mbps_pkg::PAT_BYTES-1:0]      care,
  output logic [7:0]                               byte_out,
  output logic                                     hit
);

  localparam int unsigned KW = (LEN_W > 4) ? LEN_W : 4;

  logic [7:0]    byte_r;
  logic [KW-1:0] k;
  logic          in_use;
  logic          checked;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // pattern byte compared here is len-1-CELL_IDX, on the byte entering this cell
  always_comb begin
    in_use  = ({{(32-KW){1'b0}}, KW'(len)} > 32'(CELL_IDX));
    k       = KW'(len) - KW'(1) - KW'(CELL_IDX);
    checked = in_use && ((k >> 4) == '0) && care[k[3:0]];
    hit     = !checked || (byte_in == mbps_pkg::pat_byte(pattern, k[3:0]));
  end

endmodule
`default_nettype wire

// ===== hdl/masked_byte_pattern_scanner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// wildcard byte pattern search over an addressed byte stream
// ----------------------------------------------------------------------------
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_byte_value, in_byte_address, in_region_last
// out     | output    | out_valid, out_ready, out_found, out_match_address
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one byte per cycle when in_ready; cell chain and match count update in the accept cycle
// a result is loaded into the output register at the end of the accept cycle of its byte
// in_ready is low only while a result waits and out_ready is low
// cfg_ready always high; rst_n clears count, fill, done flag, out_valid, presets cfg registers
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      in_byte_value,
  input  wire logic [31:0]                     in_byte_address,
  input  wire logic                            in_region_last,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_found,
  output logic [31:0]                          out_match_address,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);

  mbps_pkg::cfg_t cfg;

  logic [7:0]             chain [PATTERN_MAX+1];
  logic [PATTERN_MAX-1:0] hits;

  logic [LEN_W-1:0] fill_r, fill_nxt, fill_inc;
  logic [31:0]      count_r, count_nxt, count_inc;
  logic             done_r, done_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [31:0]      out_addr_r, out_addr_nxt;

  logic             accept;
  logic             scan;
  logic [LEN_W-1:0] len;
  logic [31:0]      want;
  logic             match;
  logic             report;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign scan      = accept && !done_r;

  mbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign chain[0] = in_byte_value;

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    mbps_cell #(
      .CELL_IDX (j),
      .LEN_W    (LEN_W)
    ) u_cell (
      .clk      (clk),
      .shift_en (scan),
      .byte_in  (chain[j]),
      .len      (len),
      .pattern  (cfg.pattern),
      .care     (cfg.care),
      .byte_out (chain[j+1]),
      .hit      (hits[j])
    );
  end

  always_comb begin
    if (cfg.length == 5'd0) begin
      len = LEN_W'(1);
    end else if (32'(cfg.length) > 32'(PATTERN_MAX)) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = LEN_W'(cfg.length);
    end
    want      = (cfg.target == 32'd0) ? 32'd1 : cfg.target;
    fill_inc  = (32'(fill_r) < 32'(PATTERN_MAX)) ? fill_r + LEN_W'(1) : fill_r;
    count_inc = (count_r != 32'hFFFF_FFFF) ? count_r + 32'd1 : count_r;
    match     = (fill_inc >= len) && (&hits);
    report    = match && (count_inc >= want);
  end

  always_comb begin
    fill_nxt      = fill_r;
    count_nxt     = count_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (scan) begin
      fill_nxt = fill_inc;
      if (match) begin
        count_nxt = count_inc;
      end
      if (report) begin
        done_nxt      = 1'b1;
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b1;
        out_addr_nxt  = in_byte_address - 32'(len) + 32'd1;
      end else if (in_region_last) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = 1'b0;
        out_addr_nxt  = 32'd0;
      end
    end
    if (accept && in_region_last) begin
      fill_nxt  = '0;
      count_nxt = '0;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule
`default_nettype wire
